### design/sct_pkg.sv
`timescale 1ns / 1ps
package sct_pkg;

   // result codes
   typedef enum logic [2:0] {
      KIND_CHAR     = 3'd0,
      KIND_WORD_END = 3'd1,
      KIND_PIPE     = 3'd2,
      KIND_REDIR_IN = 3'd3,
      KIND_HEREDOC  = 3'd4,
      KIND_REDIR_OUT = 3'd5,
      KIND_APPEND   = 3'd6,
      KIND_UNCLOSED = 3'd7
   } kind_type;

   // bytes the lexer looks at
   localparam logic [7:0] CHAR_PIPE   = 8'h7C;
   localparam logic [7:0] CHAR_LT     = 8'h3C;
   localparam logic [7:0] CHAR_GT     = 8'h3E;
   localparam logic [7:0] CHAR_DQUOTE = 8'h22;
   localparam logic [7:0] CHAR_SQUOTE = 8'h27;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_TAB    = 8'h09;
   localparam logic [7:0] CHAR_CR     = 8'h0D;

   localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] ch;
      logic       last;
   } res_type;

   // results produced by one item, at most two
   typedef struct packed {
      logic [1:0] cnt;
      res_type    r0;
      res_type    r1;
   } pair_type;

endpackage

### design/sct_lexer.sv
`timescale 1ns / 1ps
module sct_lexer (
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  logic [7:0]        char_in,
   input  logic              line_end,
   output sct_pkg::pair_type pair
);
   import sct_pkg::*;

   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_WORD = 2'd1,
      MODE_SQ   = 2'd2,
      MODE_DQ   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      PEND_NONE = 2'd0,
      PEND_LT   = 2'd1,
      PEND_GT   = 2'd2
   } pend_type;

   typedef struct packed {
      logic [1:0] cnt;
      kind_type   k0;
      kind_type   k1;
      mode_type   mode;
      pend_type   pend;
   } tb_type;

   mode_type mode_ff, mode_in;
   pend_type pend_ff, pend_in;

   // one byte with no operator waiting
   function automatic tb_type take_byte(mode_type mode, logic [7:0] c);
      tb_type t;
      logic   op;
      logic   blank;
      t.cnt  = 2'd0;
      t.k0   = KIND_CHAR;
      t.k1   = KIND_CHAR;
      t.mode = mode;
      t.pend = PEND_NONE;
      op     = (c == CHAR_PIPE) || (c == CHAR_LT) || (c == CHAR_GT);
      blank  = (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
      unique case (mode)
         MODE_IDLE, MODE_WORD: begin
            if (blank) begin
               if (mode == MODE_WORD) begin
                  t.cnt  = 2'd1;
                  t.k0   = KIND_WORD_END;
                  t.mode = MODE_IDLE;
               end
            end else if (op) begin
               t.mode = MODE_IDLE;
               if (mode == MODE_WORD) begin
                  t.cnt = 2'd1;
                  t.k0  = KIND_WORD_END;
               end
               if (c == CHAR_PIPE) begin
                  if (mode == MODE_WORD) begin
                     t.cnt = 2'd2;
                     t.k1  = KIND_PIPE;
                  end else begin
                     t.cnt = 2'd1;
                     t.k0  = KIND_PIPE;
                  end
               end else if (c == CHAR_LT) begin
                  t.pend = PEND_LT;
               end else begin
                  t.pend = PEND_GT;
               end
            end else if (c == CHAR_SQUOTE) begin
               t.mode = MODE_SQ;
            end else if (c == CHAR_DQUOTE) begin
               t.mode = MODE_DQ;
            end else begin
               t.cnt  = 2'd1;
               t.k0   = KIND_CHAR;
               t.mode = MODE_WORD;
            end
         end
         MODE_SQ: begin
            if (c == CHAR_SQUOTE) begin
               t.mode = MODE_WORD;
            end else begin
               t.cnt = 2'd1;
               t.k0  = KIND_CHAR;
            end
         end
         MODE_DQ: begin
            if (c == CHAR_DQUOTE) begin
               t.mode = MODE_WORD;
            end else begin
               t.cnt = 2'd1;
               t.k0  = KIND_CHAR;
            end
         end
         default: begin
            t.mode = MODE_IDLE;
         end
      endcase
      return t;
   endfunction

   always_comb begin
      tb_type     tb;
      logic [7:0] same;
      kind_type   k0;
      kind_type   k1;
      logic [1:0] cnt;
      tb      = take_byte(mode_ff, char_in);
      same    = (pend_ff == PEND_LT) ? CHAR_LT : CHAR_GT;
      k0      = KIND_CHAR;
      k1      = KIND_CHAR;
      cnt     = 2'd0;
      mode_in = mode_ff;
      pend_in = pend_ff;
      if (line_end) begin
         mode_in = MODE_IDLE;
         pend_in = PEND_NONE;
         if (pend_ff == PEND_LT) begin
            cnt = 2'd1;
            k0  = KIND_REDIR_IN;
         end else if (pend_ff == PEND_GT) begin
            cnt = 2'd1;
            k0  = KIND_REDIR_OUT;
         end else if (mode_ff == MODE_WORD) begin
            cnt = 2'd1;
            k0  = KIND_WORD_END;
         end else if ((mode_ff == MODE_SQ) || (mode_ff == MODE_DQ)) begin
            cnt = 2'd1;
            k0  = KIND_UNCLOSED;
         end
      end else if ((pend_ff == PEND_LT) || (pend_ff == PEND_GT)) begin
         if (char_in == same) begin
            cnt     = 2'd1;
            k0      = (pend_ff == PEND_LT) ? KIND_HEREDOC : KIND_APPEND;
            mode_in = MODE_IDLE;
            pend_in = PEND_NONE;
         end else begin
            // single form first, then the byte as seen from idle
            tb      = take_byte(MODE_IDLE, char_in);
            cnt     = 2'd1 + tb.cnt;
            k0      = (pend_ff == PEND_LT) ? KIND_REDIR_IN : KIND_REDIR_OUT;
            k1      = tb.k0;
            mode_in = tb.mode;
            pend_in = tb.pend;
         end
      end else begin
         cnt     = tb.cnt;
         k0      = tb.k0;
         k1      = tb.k1;
         mode_in = tb.mode;
         pend_in = tb.pend;
      end
      pair.cnt     = cnt;
      pair.r0.kind = k0;
      pair.r0.ch   = (k0 == KIND_CHAR) ? char_in : 8'h00;
      pair.r0.last = (cnt == 2'd1);
      pair.r1.kind = k1;
      pair.r1.ch   = (k1 == KIND_CHAR) ? char_in : 8'h00;
      pair.r1.last = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         pend_ff <= PEND_NONE;
      end else if (fire) begin
         mode_ff <= mode_in;
         pend_ff <= pend_in;
      end
   end

   // an operator is only held while no word or quote is open
   assert property (@(posedge clock) disable iff (reset)
      (pend_ff != PEND_NONE) |-> (mode_ff == MODE_IDLE))
      else $error("operator pending while a word is open");

endmodule

### design/sct_result_queue.sv
`timescale 1ns / 1ps
module sct_result_queue #(
   parameter int unsigned QUEUE_DEPTH = sct_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  sct_pkg::pair_type        pair,
   input  logic                     push,
   output logic                     room,
   output sct_pkg::res_type         head,
   output logic                     head_valid,
   input  logic                     pop
);
   import sct_pkg::*;

   localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_ROOM = CNT_W'(QUEUE_DEPTH - 2);

   res_type          mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, wr_next;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [1:0]       push_cnt;
   logic             do_pop;

   function automatic logic [PTR_W-1:0] bump(logic [PTR_W-1:0] p);
      return (p == PTR_LAST) ? '0 : p + 1'b1;
   endfunction

   assign push_cnt   = push ? pair.cnt : 2'd0;
   assign do_pop     = pop && head_valid;
   assign room       = (count_ff <= CNT_ROOM);
   assign head_valid = (count_ff != '0);
   assign head       = mem_ff[rd_ff];
   assign wr_next    = bump(wr_ff);

   always_comb begin
      wr_in = wr_ff;
      if (push_cnt == 2'd1) begin
         wr_in = wr_next;
      end else if (push_cnt == 2'd2) begin
         wr_in = bump(wr_next);
      end
      rd_in    = do_pop ? bump(rd_ff) : rd_ff;
      count_in = count_ff + CNT_W'(push_cnt) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) begin
         mem_ff[wr_ff] <= pair.r0;
      end
      if (push_cnt == 2'd2) begin
         mem_ff[wr_next] <= pair.r1;
      end
   end

   // never more results stored than entries
   assert property (@(posedge clock) disable iff (reset)
      (push_cnt != 2'd0) |->
      ((CNT_W + 1)'(count_ff) + (CNT_W + 1)'(push_cnt) <= (CNT_W + 1)'(QUEUE_DEPTH)))
      else $error("result queue overflow");

   // fill level tracks pushes and pops
   assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |->
      (count_ff == $past(count_ff) + CNT_W'($past(push_cnt)) - CNT_W'($past(do_pop))))
      else $error("result queue count out of step");

   // an empty queue with nothing pushed shows no result next cycle
   assert property (@(posedge clock) disable iff (reset)
      ((count_ff == '0) && (push_cnt == 2'd0)) |=> !head_valid)
      else $error("result shown from empty queue");

endmodule

### design/shell_command_tokenizer.sv
`timescale 1ns / 1ps
// channel  | ports   | tdata                 | tuser    | tlast
// ---------+---------+-----------------------+----------+-------------------------
// input    | req_*   | [7:0] char_in         | -        | line_end
// result   | rsp_*   | [7:0] char_out        | [2:0] kind | last result of its item
//
// one byte is taken per cycle while the queue has room; an item giving two
// results has them handed out one at a time, so a stream of such items is
// limited by the single read port of the result queue
// from input accept to first result a byte passes the input register, then
// the result queue
// reset is synchronous and active high; it returns the lexer to idle with
// no operator pending and empties the queue
// a stalled result side fills the queue and then drops req_tready
module shell_command_tokenizer #(
   parameter int unsigned QUEUE_DEPTH = sct_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   // input bytes
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] char_in
   input  logic       req_tlast,   // line_end
   // token results
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] char_out
   output logic [2:0] rsp_tuser,   // [2:0] kind
   output logic       rsp_tlast    // last
);
   import sct_pkg::*;

   // input register
   logic       in_valid_ff;
   logic [7:0] in_char_ff;
   logic       in_end_ff;

   logic       room;
   logic       fire;
   pair_type   pair;
   res_type    head;
   logic       head_valid;

   // the held byte moves on once the queue can take two results
   assign fire       = in_valid_ff && room;
   assign req_tready = !in_valid_ff || fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_char_ff <= req_tdata;
         in_end_ff  <= req_tlast;
      end
   end

   // mode and pending operator, plus the result pair for the held byte
   sct_lexer u_lexer (
      .clock    (clock),
      .reset    (reset),
      .fire     (fire),
      .char_in  (in_char_ff),
      .line_end (in_end_ff),
      .pair     (pair)
   );

   // results wait here, one handed out per cycle while rsp_tready is high
   sct_result_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .pair       (pair),
      .push       (fire),
      .room       (room),
      .head       (head),
      .head_valid (head_valid),
      .pop        (rsp_tready)
   );

   assign rsp_tvalid = head_valid;
   assign rsp_tdata  = head.ch;
   assign rsp_tuser  = head.kind;
   assign rsp_tlast  = head.last;

endmodule
